// ----- design/ams_pkg.sv -----
// Shared types, constants and opcodes of the accumulator machine step core.
// No dependencies.
`timescale 1ns / 1ps
package ams_pkg;
   localparam int MemWords = 4096;
   localparam int AddrW = $clog2(MemWords);
   localparam int PcW = 13;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_EXEC = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic [2:0] ST_RUN = 3'd0;
   localparam logic [2:0] ST_HALT = 3'd1;
   localparam logic [2:0] ST_OVF = 3'd2;
   localparam logic [2:0] ST_DIV0 = 3'd3;
   localparam logic [2:0] ST_BADIN = 3'd4;
   localparam logic [2:0] ST_BADOP = 3'd5;
   localparam logic [2:0] ST_END = 3'd6;

   localparam logic [19:0] OP_READ = 20'd10;
   localparam logic [19:0] OP_WRITE = 20'd11;
   localparam logic [19:0] OP_NEWLINE = 20'd12;
   localparam logic [19:0] OP_LOAD = 20'd20;
   localparam logic [19:0] OP_STORE = 20'd21;
   localparam logic [19:0] OP_ADD = 20'd30;
   localparam logic [19:0] OP_SUB = 20'd31;
   localparam logic [19:0] OP_DIV = 20'd32;
   localparam logic [19:0] OP_MUL = 20'd33;
   localparam logic [19:0] OP_BR = 20'd40;
   localparam logic [19:0] OP_BRNEG = 20'd41;
   localparam logic [19:0] OP_BRZERO = 20'd42;
   localparam logic [19:0] OP_HALT = 20'd43;
   localparam logic [19:0] OP_TRACE = 20'd44;
   localparam logic [19:0] OP_MOD = 20'd50;
   localparam logic [19:0] OP_POW = 20'd51;

   localparam logic signed [31:0] AccLimit = 32'sd1048575;
   localparam logic signed [31:0] ReadLimit = 32'sd10000000;

   typedef struct packed {
      logic [1:0] cmd;
      logic [11:0] load_addr;
      logic signed [31:0] load_word;
      logic signed [31:0] in_value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic out_valid;
      logic signed [31:0] out_value;
      logic newline;
      logic [12:0] pc_now;
      logic signed [31:0] acc_now;
   } rsp_type;

   // control between sequencer and arithmetic unit
   typedef struct packed {
      logic start;
      logic [1:0] kind;   // 0 divide, 1 modulo, 2 power
   } alu_ctl_type;

   localparam logic [1:0] ALU_DIV = 2'd0;
   localparam logic [1:0] ALU_MOD = 2'd1;
   localparam logic [1:0] ALU_POW = 2'd2;
endpackage

// ----- design/ams_stream_if.sv -----
// Valid/ready channel carrying one request or response word.
// Depends on ams_pkg.
`timescale 1ns / 1ps
interface ams_req_if;
   logic valid;
   logic ready;
   ams_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ams_rsp_if;
   logic valid;
   logic ready;
   ams_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- design/ams_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ams_ram #(
   parameter int Width = 32,
   parameter int Depth = 4096
) (
   input logic clock,
   input logic we,
   input logic [$clog2(Depth)-1:0] addr,
   input logic [Width-1:0] wdata,
   output logic [Width-1:0] rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ----- design/ams_alu.sv -----
// Iterative divide/modulo (restoring, one bit a cycle) and power
// (square and multiply, one exponent bit per multiply and square state pair). Depends on ams_pkg.
`timescale 1ns / 1ps
module ams_alu (
   input logic clock,
   input logic reset,
   input ams_pkg::alu_ctl_type ctl,
   input logic [31:0] a,
   input logic [31:0] b,
   output logic done,
   output logic [31:0] result
);
   import ams_pkg::*;
   typedef enum logic [2:0] {IDLE, DIV, POW_MUL, POW_SQ, FIN} state_type;
   state_type state_ff;
   logic [1:0] kind_ff;
   logic [5:0] cnt_ff;
   logic [31:0] quo_ff, rem_ff, den_ff, base_ff, exp_ff, res_ff;
   logic neg_q_ff, neg_r_ff;
   logic [32:0] trial;
   logic [31:0] rem_sh;

   assign rem_sh = {rem_ff[30:0], quo_ff[31]};
   assign trial = {1'b0, rem_sh} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done <= 1'b0;
      end else begin
         done <= 1'b0;
         unique case (state_ff)
            IDLE: if (ctl.start) begin
               kind_ff <= ctl.kind;
               cnt_ff <= 6'd0;
               if (ctl.kind == ALU_POW) begin
                  base_ff <= a;
                  exp_ff <= b;
                  res_ff <= 32'd1;
                  state_ff <= POW_MUL;
               end else begin
                  quo_ff <= a[31] ? -a : a;
                  den_ff <= b[31] ? -b : b;
                  rem_ff <= 32'd0;
                  neg_q_ff <= a[31] ^ b[31];
                  neg_r_ff <= a[31];
                  state_ff <= DIV;
               end
            end
            DIV: begin
               // shift in next dividend bit, subtract when it fits
               if (!trial[32]) begin
                  rem_ff <= trial[31:0];
                  quo_ff <= {quo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[30:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) state_ff <= FIN;
            end
            POW_MUL: begin
               if (exp_ff == 32'd0) state_ff <= FIN;
               else begin
                  if (exp_ff[0]) res_ff <= res_ff * base_ff;
                  state_ff <= POW_SQ;
               end
            end
            POW_SQ: begin
               base_ff <= base_ff * base_ff;
               exp_ff <= exp_ff >> 1;
               state_ff <= POW_MUL;
            end
            FIN: begin
               unique case (kind_ff)
                  ALU_DIV: result <= neg_q_ff ? -quo_ff : quo_ff;
                  ALU_MOD: result <= neg_r_ff ? -rem_ff : rem_ff;
                  default: result <= res_ff;
               endcase
               done <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// ----- design/ams_seq.sv -----
// Instruction sequencer: clears memory after reset, then fetches, reads the
// operand, executes and writes back. Depends on ams_pkg, ams_ram, ams_alu.
`timescale 1ns / 1ps
module ams_seq (
   input logic clock,
   input logic reset,
   ams_req_if.sink req,
   ams_rsp_if.source rsp
);
   import ams_pkg::*;
   typedef enum logic [2:0] {
      CLEAR, IDLE, FETCH, DECODE, OPER, EXEC, WAIT_ALU, RESP
   } state_type;
   state_type state_ff;
   logic [AddrW:0] clr_ff;
   logic [31:0] acc_ff;
   logic [PcW-1:0] pc_ff;
   logic [2:0] stop_ff;
   req_type item_ff;
   logic [31:0] word_ff;
   rsp_type out_ff;
   logic rsp_valid_ff;

   logic we;
   logic [AddrW-1:0] addr;
   logic [31:0] wdata, rdata;
   alu_ctl_type alu_ctl;
   logic alu_done;
   logic [31:0] alu_res;

   logic [19:0] op;
   logic [AddrW-1:0] oaddr;
   logic signed [31:0] acc_s, m_s, in_s;
   logic acc_ovf;

   assign op = word_ff[31] ? 20'hFFFFF : word_ff[31:12];
   assign oaddr = word_ff[AddrW-1:0];
   assign acc_s = acc_ff;
   assign m_s = rdata;
   assign in_s = item_ff.in_value;
   assign acc_ovf = (acc_s > AccLimit) || (acc_s < -AccLimit);

   ams_ram #(.Width(32), .Depth(MemWords)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );
   ams_alu u_alu (
      .clock(clock), .reset(reset), .ctl(alu_ctl), .a(acc_ff), .b(rdata),
      .done(alu_done), .result(alu_res)
   );

   assign req.ready = (state_ff == IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = out_ff;

   always_comb begin
      we = 1'b0;
      addr = pc_ff[AddrW-1:0];
      wdata = 32'd0;
      alu_ctl = '0;
      unique case (state_ff)
         CLEAR: begin
            we = 1'b1;
            addr = clr_ff[AddrW-1:0];
         end
         IDLE: begin
            if (req.valid && req.data.cmd == CMD_LOAD && !rsp_valid_ff) begin
               we = 1'b1;
               addr = req.data.load_addr[AddrW-1:0];
               wdata = req.data.load_word;
            end
         end
         DECODE: addr = oaddr;
         OPER: addr = oaddr;
         EXEC: begin
            addr = oaddr;
            // an overflowed accumulator stops before the instruction runs
            if (!acc_ovf && op == OP_READ) begin
               we = 1'b1;
               wdata = item_ff.in_value;
            end else if (!acc_ovf && op == OP_STORE) begin
               we = 1'b1;
               wdata = acc_ff;
            end
            alu_ctl.start = !acc_ovf &&
               ((((op == OP_DIV) || (op == OP_MOD)) && rdata != 32'd0)
               || ((op == OP_POW) && m_s >= 32'sd2));
            alu_ctl.kind = (op == OP_DIV) ? ALU_DIV : (op == OP_MOD) ? ALU_MOD : ALU_POW;
         end
         WAIT_ALU: addr = oaddr;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         clr_ff <= '0;
         acc_ff <= 32'd0;
         pc_ff <= '0;
         stop_ff <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AddrW + 1)'(MemWords - 1)) state_ff <= IDLE;
            end
            IDLE: if (req.valid && req.ready) begin
               item_ff <= req.data;
               out_ff.out_valid <= 1'b0;
               out_ff.out_value <= 32'd0;
               out_ff.newline <= 1'b0;
               state_ff <= RESP;
               unique case (req.data.cmd)
                  CMD_EXEC: if (stop_ff == ST_RUN) begin
                     if (pc_ff >= PcW'(MemWords)) stop_ff <= ST_END;
                     else state_ff <= FETCH;
                  end
                  CMD_RESTART: begin
                     pc_ff <= '0;
                     acc_ff <= 32'd0;
                     stop_ff <= ST_RUN;
                  end
                  default: ;
               endcase
            end
            FETCH: state_ff <= DECODE;
            DECODE: begin
               word_ff <= rdata;
               state_ff <= OPER;
            end
            OPER: state_ff <= EXEC;
            EXEC: begin
               state_ff <= RESP;
               if (op == OP_HALT) stop_ff <= ST_HALT;
               else if (acc_ovf) stop_ff <= ST_OVF;
               else begin
                  priority case (op)
                     OP_READ: if (in_s >= ReadLimit || in_s <= -ReadLimit)
                        stop_ff <= ST_BADIN;
                     else pc_ff <= pc_ff + 1'b1;
                     OP_WRITE: begin
                        out_ff.out_valid <= 1'b1;
                        out_ff.out_value <= rdata;
                        pc_ff <= pc_ff + 1'b1;
                     end
                     OP_NEWLINE: begin
                        out_ff.newline <= 1'b1;
                        pc_ff <= pc_ff + 1'b1;
                     end
                     OP_LOAD: begin acc_ff <= rdata; pc_ff <= pc_ff + 1'b1; end
                     OP_STORE, OP_TRACE: pc_ff <= pc_ff + 1'b1;
                     OP_ADD: begin acc_ff <= acc_ff + rdata; pc_ff <= pc_ff + 1'b1; end
                     OP_SUB: begin acc_ff <= acc_ff - rdata; pc_ff <= pc_ff + 1'b1; end
                     OP_MUL: state_ff <= WAIT_ALU;
                     OP_DIV, OP_MOD: if (rdata == 32'd0) stop_ff <= ST_DIV0;
                     else state_ff <= WAIT_ALU;
                     OP_POW: if (m_s >= 32'sd2) state_ff <= WAIT_ALU;
                     else pc_ff <= pc_ff + 1'b1;
                     OP_BR: pc_ff <= PcW'(word_ff[11:0]);
                     OP_BRNEG: pc_ff <= acc_s < 0 ? PcW'(word_ff[11:0]) : pc_ff + 1'b1;
                     OP_BRZERO: pc_ff <= acc_s == 0 ? PcW'(word_ff[11:0]) : pc_ff + 1'b1;
                     default: stop_ff <= ST_BADOP;
                  endcase
               end
            end
            WAIT_ALU: begin
               // multiply completes here in one registered step
               if (op == OP_MUL) begin
                  acc_ff <= acc_ff * rdata;
                  pc_ff <= pc_ff + 1'b1;
                  state_ff <= RESP;
               end else if (alu_done) begin
                  acc_ff <= alu_res;
                  pc_ff <= pc_ff + 1'b1;
                  state_ff <= RESP;
               end
            end
            RESP: begin
               if (pc_ff >= PcW'(MemWords) && stop_ff == ST_RUN) stop_ff <= ST_END;
               out_ff.status <= (pc_ff >= PcW'(MemWords) && stop_ff == ST_RUN)
                  ? ST_END : stop_ff;
               out_ff.pc_now <= pc_ff;
               out_ff.acc_now <= acc_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// ----- design/accumulator_machine_step_core.sv -----
// Accumulator machine step core: top level.
// Execute passes the fetch, decode, operand and execute states; multiply adds
// one registered step; divide and modulo run the iterative unit (one quotient
// bit a cycle); power squares and multiplies per exponent bit. One item at a
// time, set by the sequencer. Reset: synchronous; a clearing pass then zeros
// the memory, one word a cycle, accepting no item meanwhile. Depends on ams_seq.
`timescale 1ns / 1ps
module accumulator_machine_step_core (
   input logic clock,
   input logic reset,
   ams_req_if.sink req,
   ams_rsp_if.source rsp
);
   ams_seq u_seq (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
endmodule

// ----- verif/tb_accumulator_machine_step_core.sv -----
// Testbench for accumulator_machine_step_core: random machine programs with a
// self-checking scoreboard. Depends on ams_pkg, ams_stream_if and the core.
`timescale 1ns / 1ps
module tb_accumulator_machine_step_core;
   import ams_pkg::*;

   class machine_scoreboard;
      logic [31:0] mem [MemWords];
      logic [31:0] acc;
      logic [12:0] pc;
      logic [2:0] stat;
      rsp_type expected_q [$];
      int errors;
      int checked;
      int stops [7];

      function new();
         foreach (mem[i]) mem[i] = '0;
         acc = '0;
         pc = '0;
         stat = ST_RUN;
         errors = 0;
         checked = 0;
      endfunction

      function logic [31:0] wrap_power(logic [31:0] base, logic [31:0] e);
         logic [31:0] r;
         r = 32'd1;
         for (int i = 0; i < 32; i++) begin
            if (e[i]) r = r * base;
            base = base * base;
         end
         return r;
      endfunction

      // execute one instruction against the modeled state
      function void run_instr(logic [31:0] in_value, ref rsp_type r);
         logic [31:0] word, m;
         logic [19:0] op;
         logic [11:0] addr;
         logic [12:0] nxt;
         longint a, b;
         if (pc >= MemWords) begin
            stat = ST_END;
            return;
         end
         word = mem[pc];
         op = word[31] ? '1 : word[31:12];
         addr = word[11:0];
         nxt = pc + 13'd1;
         if (op == OP_HALT) begin
            stat = ST_HALT;
            return;
         end
         a = $signed(acc);
         if (a > AccLimit || a < -AccLimit) begin
            stat = ST_OVF;
            return;
         end
         m = mem[addr];
         b = $signed(m);
         case (op)
            OP_READ: begin
               mem[addr] = in_value;
               if ($signed(in_value) >= ReadLimit || $signed(in_value) <= -ReadLimit) begin
                  stat = ST_BADIN;
                  return;
               end
            end
            OP_WRITE: begin
               r.out_valid = 1'b1;
               r.out_value = m;
            end
            OP_NEWLINE: r.newline = 1'b1;
            OP_LOAD: acc = m;
            OP_STORE: mem[addr] = acc;
            OP_ADD: acc = acc + m;
            OP_SUB: acc = acc - m;
            OP_DIV, OP_MOD: begin
               if (b == 0) begin
                  stat = ST_DIV0;
                  return;
               end
               acc = (op == OP_DIV) ? 32'(a / b) : 32'(a % b);
            end
            OP_MUL: acc = acc * m;
            OP_BR: nxt = {1'b0, addr};
            OP_BRNEG: if (a < 0) nxt = {1'b0, addr};
            OP_BRZERO: if (a == 0) nxt = {1'b0, addr};
            OP_TRACE: ;
            OP_POW: if (b >= 2) acc = wrap_power(acc, m);
            default: begin
               stat = ST_BADOP;
               return;
            end
         endcase
         pc = nxt;
         if (pc >= MemWords) stat = ST_END;
      endfunction

      function void note_request(req_type q);
         rsp_type r;
         r = '0;
         case (q.cmd)
            CMD_LOAD: mem[q.load_addr] = q.load_word;
            CMD_EXEC: if (stat == ST_RUN) run_instr(q.in_value, r);
            CMD_RESTART: begin
               pc = '0;
               acc = '0;
               stat = ST_RUN;
            end
            default: ;
         endcase
         r.status = stat;
         r.pc_now = pc;
         r.acc_now = acc;
         stops[stat]++;
         expected_q.push_back(r);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response %p", $time, got);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         checked++;
         if (got.status !== exp.status || got.out_valid !== exp.out_valid ||
             got.out_value !== exp.out_value || got.newline !== exp.newline ||
             got.pc_now !== exp.pc_now || got.acc_now !== exp.acc_now) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp, got);
            errors++;
         end
      endfunction
   endclass

   localparam int IdleLimit = 30000;

   logic clock;
   logic reset;
   ams_req_if req_ch ();
   ams_rsp_if rsp_ch ();
   machine_scoreboard sb;
   int gap_pct;
   int stall_pct;
   int words_sent;
   int quiet_cycles;
   logic [19:0] op_pool [16];

   accumulator_machine_step_core uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // hold ready low at random for the stall phases
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
         $display("watchdog expired at %0t", $time);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [31:0] instr(logic [19:0] op, logic [11:0] addr);
      return {op, addr};
   endfunction

   task automatic send_word(logic [1:0] cmd, logic [11:0] addr, logic [31:0] word,
                            logic [31:0] in_value);
      while ($urandom_range(99) < gap_pct) @(negedge clock);
      req_ch.data.cmd = cmd;
      req_ch.data.load_addr = addr;
      req_ch.data.load_word = word;
      req_ch.data.in_value = in_value;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      req_ch.valid = 1'b0;
      words_sent++;
   endtask

   task automatic load_word(logic [11:0] addr, logic [31:0] word);
      send_word(CMD_LOAD, addr, word, $urandom);
   endtask

   task automatic exec_step(logic [31:0] in_value);
      send_word(CMD_EXEC, $urandom, $urandom, in_value);
   endtask

   task automatic restart();
      send_word(CMD_RESTART, $urandom, $urandom, $urandom);
   endtask

   // let every expected response drain, then the core settle
   task automatic drain();
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic logic [31:0] data_value();
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'd0;
         2: return 32'($urandom_range(1048575)) * ($urandom_range(1) ? 1 : -1);
         3: return $urandom_range(2, 40);
         default: return 32'($signed($urandom_range(100)) - 50);
      endcase
   endfunction

   function automatic logic [31:0] read_value();
      case ($urandom_range(9))
         0: return $urandom;
         1: return ReadLimit;
         2: return -ReadLimit;
         3: return ReadLimit - 1;
         4: return -(ReadLimit - 1);
         default: return 32'($signed($urandom_range(200)) - 100);
      endcase
   endfunction

   // load a short random program and data region, then step through it, mixing in stray loads and unknown commands
   task automatic run_program();
      int n;
      logic [19:0] op;
      logic [11:0] addr;
      n = $urandom_range(2, 12);
      for (int i = 0; i < n; i++) begin
         op = op_pool[$urandom_range(15)];
         if (op == OP_BR || op == OP_BRNEG || op == OP_BRZERO)
            addr = $urandom_range(n);
         else
            addr = $urandom_range(16, 31);
         case ($urandom_range(19))
            0: load_word(i, 32'h8000_0000 | $urandom);
            1: load_word(i, instr($urandom_range(1023), addr));
            2: load_word(i, instr(op, $urandom));
            default: load_word(i, instr(op, addr));
         endcase
      end
      repeat ($urandom_range(3, 8)) load_word($urandom_range(16, 31), data_value());
      restart();
      repeat (n + $urandom_range(8)) begin
         case ($urandom_range(19))
            0: send_word(2'd3, $urandom, $urandom, $urandom);
            1: load_word($urandom, $urandom);
            default: exec_step(read_value());
         endcase
      end
   endtask

   initial begin
      op_pool = '{OP_READ, OP_WRITE, OP_NEWLINE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
                  OP_DIV, OP_MUL, OP_BR, OP_BRNEG, OP_BRZERO, OP_HALT, OP_TRACE,
                  OP_MOD, OP_POW};
      sb = new();
      gap_pct = 0;
      stall_pct = 0;
      words_sent = 0;
      quiet_cycles = 0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, end of memory, stopped machine, bad opcode, zero divisor, halt
      load_word(12'd4095, instr(OP_TRACE, 12'd0));
      load_word(12'd0, instr(OP_READ, 12'd200));
      load_word(12'd1, instr(OP_WRITE, 12'd200));
      load_word(12'd2, instr(OP_BR, 12'd4095));
      restart();
      exec_step(32'h7fff_ffff);
      restart();
      exec_step(32'd5);
      exec_step(32'd0);
      exec_step(32'd0);
      exec_step(32'd0);
      exec_step(32'd0);
      send_word(2'd3, 12'hfff, 32'hffff_ffff, 32'hffff_ffff);
      restart();
      load_word(12'd0, 32'h8000_0000);
      exec_step(32'd0);
      restart();
      load_word(12'd0, instr(OP_DIV, 12'd201));
      exec_step(32'd0);
      load_word(12'd201, 32'h7fff_ffff);
      load_word(12'd0, instr(OP_HALT, 12'd0));
      restart();
      exec_step(32'd0);
      drain();

      while (words_sent < 600) begin
         if (words_sent >= 450) begin
            gap_pct = 19;
            stall_pct = 19;
         end else if (words_sent >= 300) begin
            gap_pct = 0;
            stall_pct = 66;
         end else if (words_sent >= 150) begin
            gap_pct = 66;
            stall_pct = 0;
         end
         run_program();
         if ($urandom_range(3) == 0) drain();
      end
      drain();

      $display("Checked %0d responses over %0d words: %0d running, %0d halted, %0d overflow,",
               sb.checked, words_sent, sb.stops[ST_RUN], sb.stops[ST_HALT], sb.stops[ST_OVF]);
      $display("  %0d div-by-zero, %0d bad input, %0d bad opcode, %0d end of memory",
               sb.stops[ST_DIV0], sb.stops[ST_BADIN], sb.stops[ST_BADOP], sb.stops[ST_END]);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
design/ams_pkg.sv
design/ams_stream_if.sv
design/ams_ram.sv
design/ams_alu.sv
design/ams_seq.sv
design/accumulator_machine_step_core.sv
verif/tb_accumulator_machine_step_core.sv
